// ===== hw/rtl/pidq8_pkg.sv =====
// ============================================================================
// pidq8_pkg
// Shared types, codes and helpers for the Q8.8 PID controller.
// ============================================================================
package pidq8_pkg;

  // Default number of fraction bits in the gains
  localparam int FRAC_BITS_DEF = 8;

  // Working width of the wide sums; sized for the largest fraction width (15)
  localparam int SUM_W = 35;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_VALUE = 3'd6;

  // Item function codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Reset values of the rails
  localparam logic signed [15:0] RAIL_LOW_RST  = 16'sh8000;
  localparam logic signed [15:0] RAIL_HIGH_RST = 16'sh7fff;

  // Configuration register set
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic signed [15:0] rail_low;
    logic signed [15:0] rail_high;
    logic               manual_mode;
    logic signed [15:0] manual_value;
  } cfg_t;

  // Controller history flags
  typedef struct packed {
    logic have_last;
    logic skip_integrate;
  } hist_t;

  // Raise to lo first, then lower to hi (inverted rails end at hi)
  function automatic logic signed [SUM_W-1:0] clamp_seq(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lo,
    input logic signed [SUM_W-1:0] hi
  );
    logic signed [SUM_W-1:0] res;
    res = v;
    if (res < lo) res = lo;
    if (res > hi) res = hi;
    return res;
  endfunction

endpackage

// ===== hw/rtl/pidq8_if.sv =====
// ============================================================================
// pidq8 channel interfaces
// Valid/ready channels for update items and controller results.
// ============================================================================

// Update item channel
interface pidq8_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [15:0] target;
  logic signed [15:0] sensed;

  modport source (output valid, output func, output target, output sensed, input ready);
  modport sink   (input valid, input func, input target, input sensed, output ready);
endinterface

// Result channel
interface pidq8_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== hw/rtl/pidq8_cfg_regs.sv =====
// ============================================================================
// pidq8_cfg_regs
// Write-only configuration register file of the PID controller.
// ============================================================================
module pidq8_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pidq8_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                     cfg_wdata,
  output pidq8_pkg::cfg_t                 cfg
);

  pidq8_pkg::cfg_t cfg_r;
  pidq8_pkg::cfg_t cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        pidq8_pkg::REG_GAIN_P:       cfg_nxt.gain_p       = cfg_wdata;
        pidq8_pkg::REG_GAIN_I:       cfg_nxt.gain_i       = cfg_wdata;
        pidq8_pkg::REG_GAIN_D:       cfg_nxt.gain_d       = cfg_wdata;
        pidq8_pkg::REG_RAIL_LOW:     cfg_nxt.rail_low     = cfg_wdata;
        pidq8_pkg::REG_RAIL_HIGH:    cfg_nxt.rail_high    = cfg_wdata;
        pidq8_pkg::REG_MANUAL_MODE:  cfg_nxt.manual_mode  = cfg_wdata[0];
        pidq8_pkg::REG_MANUAL_VALUE: cfg_nxt.manual_value = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= '0;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.rail_low     <= pidq8_pkg::RAIL_LOW_RST;
      cfg_r.rail_high    <= pidq8_pkg::RAIL_HIGH_RST;
      cfg_r.manual_mode  <= 1'b0;
      cfg_r.manual_value <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/pidq8_datapath.sv =====
// ============================================================================
// pidq8_datapath
// One-pass PID update: P, I, D terms, integrator clamp, output saturation, manual mode and clear items.
// ============================================================================
module pidq8_datapath #(
  parameter int FRAC_BITS = pidq8_pkg::FRAC_BITS_DEF,
  parameter int ACC_W     = 16 + FRAC_BITS
) (
  input  logic                     func,
  input  logic signed [15:0]       target,
  input  logic signed [15:0]       sensed,
  input  pidq8_pkg::cfg_t          cfg,
  input  logic signed [ACC_W-1:0]  acc,
  input  logic signed [15:0]       last_sensed,
  input  pidq8_pkg::hist_t         hist,
  output logic signed [15:0]       drive,
  output logic signed [ACC_W-1:0]  acc_nxt,
  output logic signed [15:0]       last_nxt,
  output pidq8_pkg::hist_t         hist_nxt
);

  localparam int SW = pidq8_pkg::SUM_W;

  logic signed [15:0]    err;
  logic signed [15:0]    dmeas;
  logic signed [31:0]    p_prod;
  logic signed [31:0]    i_prod;
  logic signed [31:0]    d_prod;
  logic signed [31:0]    d_term;
  logic signed [SW-1:0]  p_w;
  logic signed [SW-1:0]  d_w;
  logic signed [SW-1:0]  i_w;
  logic signed [SW-1:0]  lo_w;
  logic signed [SW-1:0]  hi_w;
  logic signed [SW-1:0]  lo_q;
  logic signed [SW-1:0]  hi_q;
  logic signed [SW-1:0]  acc_auto;
  logic signed [SW-1:0]  total;
  logic signed [SW-1:0]  drive_auto;
  logic signed [SW-1:0]  drive_man;
  logic signed [SW-1:0]  acc_man;
  logic signed [SW-1:0]  drive_sel;
  logic signed [SW-1:0]  acc_sel;

  // Error and measurement change, both wrapped to 16 bits
  assign err   = target - sensed;
  assign dmeas = hist.have_last ? (sensed - last_sensed) : 16'sd0;

  // Gain products
  assign p_prod = cfg.gain_p * err;
  assign i_prod = cfg.gain_i * err;
  assign d_prod = cfg.gain_d * dmeas;
  assign d_term = 32'sd0 - d_prod;

  assign p_w = SW'(p_prod);
  assign d_w = SW'(d_term);
  assign i_w = hist.skip_integrate ? '0 : SW'(i_prod);

  // Rails, plain and scaled
  assign lo_w = SW'(cfg.rail_low);
  assign hi_w = SW'(cfg.rail_high);
  assign lo_q = lo_w <<< FRAC_BITS;
  assign hi_q = hi_w <<< FRAC_BITS;

  // Automatic: integrate, clamp, sum, floor shift, saturate
  assign acc_auto   = pidq8_pkg::clamp_seq(SW'(acc) + i_w, lo_q, hi_q);
  assign total      = p_w + acc_auto + d_w;
  assign drive_auto = pidq8_pkg::clamp_seq(total >>> FRAC_BITS, lo_w, hi_w);

  // Manual: hold clamped value and back-calculate the integrator
  assign drive_man = pidq8_pkg::clamp_seq(SW'(cfg.manual_value), lo_w, hi_w);
  assign acc_man   = pidq8_pkg::clamp_seq((drive_man <<< FRAC_BITS) - p_w - d_w, lo_q, hi_q);

  assign drive_sel = cfg.manual_mode ? drive_man : drive_auto;
  assign acc_sel   = cfg.manual_mode ? acc_man : acc_auto;

  // Next state; a clear item resets the history and keeps last_sensed
  always_comb begin
    drive = drive_sel[15:0];
    if (func == pidq8_pkg::FUNC_CLEAR) begin
      acc_nxt                 = '0;
      last_nxt                = last_sensed;
      hist_nxt.have_last      = 1'b0;
      hist_nxt.skip_integrate = 1'b0;
    end else begin
      acc_nxt                 = acc_sel[ACC_W-1:0];
      last_nxt                = sensed;
      hist_nxt.have_last      = 1'b1;
      hist_nxt.skip_integrate = cfg.manual_mode;
    end
  end

endmodule

// ===== hw/rtl/pid_q8_controller.sv =====
// ============================================================================
// pid_q8_controller
// Fixed-point PID controller with signed Q8.8 gains and clamped output.
// ============================================================================
// Usage:
//   in_item  : update items (func, target, sensed); a transfer happens when
//              valid and ready are both high. func = clear zeroes the
//              integrator and history and produces no result.
//   out_item : one drive value per update item, in order.
//   cfg_*    : write-only register port; write only while the block is idle.
// Path: an item passes through the input register and then the result register,
//   which raises out_item.valid; the result transfers once out_item.ready is
//   high.
// Throughput: one item per cycle unless a result waits for out_item.ready;
//   the integrator and history feedback is a single combinational pass from
//   the input register into the state registers, which sets that rate.
// Reset: synchronous, active low; clears both stages, the integrator, the
//   history and the configuration to its reset values.
// Stall: while a result waits for ready, the input register still takes
//   one item; after that in_item.ready drops until the result is taken.
// ============================================================================
module pid_q8_controller #(
  parameter int FRAC_BITS = pidq8_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pidq8_in_if.sink                        in_item,
  pidq8_out_if.source                     out_item,
  input  logic                            cfg_we,
  input  logic [pidq8_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                     cfg_wdata
);

  localparam int ACC_W = 16 + FRAC_BITS;

  pidq8_pkg::cfg_t   cfg;

  // Input stage
  logic               s0_valid_r;
  logic               s0_func_r;
  logic signed [15:0] s0_target_r;
  logic signed [15:0] s0_sensed_r;

  // Result stage
  logic               out_valid_r;
  logic signed [15:0] drive_r;

  // Controller state
  logic signed [ACC_W-1:0] acc_r;
  logic signed [15:0]      last_sensed_r;
  pidq8_pkg::hist_t        hist_r;

  // Datapath results
  logic signed [15:0]      drive_nxt;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [15:0]      last_sensed_nxt;
  pidq8_pkg::hist_t        hist_nxt;

  logic advance;
  logic in_ready;
  logic in_xfer;

  pidq8_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidq8_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_dp (
    .func        (s0_func_r),
    .target      (s0_target_r),
    .sensed      (s0_sensed_r),
    .cfg         (cfg),
    .acc         (acc_r),
    .last_sensed (last_sensed_r),
    .hist        (hist_r),
    .drive       (drive_nxt),
    .acc_nxt     (acc_nxt),
    .last_nxt    (last_sensed_nxt),
    .hist_nxt    (hist_nxt)
  );

  // Handshake: result register frees when empty or taken
  assign advance  = !out_valid_r || out_item.ready;
  assign in_ready = !s0_valid_r || advance;
  assign in_xfer  = in_item.valid && in_ready;

  assign in_item.ready  = in_ready;
  assign out_item.valid = out_valid_r;
  assign out_item.drive = drive_r;

  // Control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      acc_r         <= '0;
      last_sensed_r <= '0;
      hist_r        <= '0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_item.valid;
      end
      if (advance) begin
        out_valid_r <= s0_valid_r && (s0_func_r == pidq8_pkg::FUNC_UPDATE);
      end
      if (s0_valid_r && advance) begin
        acc_r         <= acc_nxt;
        last_sensed_r <= last_sensed_nxt;
        hist_r        <= hist_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_func_r   <= in_item.func;
      s0_target_r <= in_item.target;
      s0_sensed_r <= in_item.sensed;
    end
    if (s0_valid_r && advance) begin
      drive_r <= drive_nxt;
    end
  end

  // A clear item never produces a result
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && advance && s0_func_r == pidq8_pkg::FUNC_CLEAR) |=> !out_valid_r)
    else $error("clear item produced a result");

  // An update item leaves valid derivative history behind
  a_update_sets_history: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && advance && s0_func_r == pidq8_pkg::FUNC_UPDATE) |=> hist_r.have_last)
    else $error("update did not record last measurement");

  // A stalled input stage keeps its item
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> (s0_valid_r && $stable(s0_sensed_r)))
    else $error("input stage lost an item under stall");

endmodule
